// ===== src/slps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slps_pkg
// Shared types and constants for the status LED pattern sequencer.
// ----------------------------------------------------------------------------
package slps_pkg;

    localparam int MODE_W    = 3;
    localparam int ELAPSED_W = 21;
    localparam int COUNT_W   = 8;
    localparam int IDLE_W    = 20;
    localparam int DUR_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 20;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

    // mode codes
    localparam logic [MODE_W-1:0] MODE_IDLE     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SENDING  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CHARGING = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CHG_DONE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SEARCH   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SLEEPING = 3'd5;

    // item kinds
    localparam logic CMD_TICK     = 1'b0;
    localparam logic CMD_SET_MODE = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_MS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLASH_MS      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEND_FLASHES  = 2'd3;

    // register reset values
    localparam logic [IDLE_W-1:0]  IDLE_INTERVAL_RST = 20'd30000;
    localparam logic [DUR_W-1:0]   BLINK_MS_RST      = 16'd300;
    localparam logic [DUR_W-1:0]   FLASH_MS_RST      = 16'd100;
    localparam logic [COUNT_W-1:0] SEND_FLASHES_RST  = 8'd2;

    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic                 idle_flashing;
        logic                 flash_lit_phase;
        logic [COUNT_W-1:0]   flash_count;
        logic [ELAPSED_W-1:0] elapsed_ms;
        logic                 led_lit;
    } slps_state_t;

    typedef struct packed {
        logic [IDLE_W-1:0]  idle_interval_ms;
        logic [DUR_W-1:0]   blink_ms;
        logic [DUR_W-1:0]   flash_ms;
        logic [COUNT_W-1:0] send_flashes;
    } slps_cfg_t;

endpackage
`default_nettype wire

// ===== src/slps_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slps_step
// Next-state logic for one tick or mode change transaction.
// ----------------------------------------------------------------------------
module slps_step (
    input  wire slps_pkg::slps_state_t st_cur,
    input  wire slps_pkg::slps_cfg_t   cfg,
    input  wire                        cmd,
    input  wire [2:0]                  new_mode,
    output slps_pkg::slps_state_t      st_nxt
);
    import slps_pkg::*;

    logic [ELAPSED_W-1:0] e_inc;
    logic                 run;
    logic [DUR_W-1:0]     dur;
    logic [COUNT_W-1:0]   target;
    logic [COUNT_W-1:0]   cnt_inc;
    logic                 done;

    always_comb begin
        st_nxt  = st_cur;
        e_inc   = (st_cur.elapsed_ms == ELAPSED_MAX) ? st_cur.elapsed_ms
                                                     : st_cur.elapsed_ms + 1'b1;
        cnt_inc = st_cur.flash_count + 1'b1;
        dur     = (st_cur.mode == MODE_SENDING) ? cfg.flash_ms : cfg.blink_ms;
        target  = (st_cur.mode == MODE_SENDING) ? cfg.send_flashes : COUNT_W'(1);
        run     = 1'b0;
        done    = 1'b0;

        if (cmd == CMD_SET_MODE) begin
            if (new_mode <= MODE_SLEEPING) begin
                st_nxt.mode    = new_mode;
                st_nxt.led_lit = (new_mode == MODE_CHARGING);
            end
        end else begin
            st_nxt.elapsed_ms = e_inc;
            case (st_cur.mode)
                MODE_IDLE: begin
                    if (!st_cur.idle_flashing) begin
                        if (e_inc > ELAPSED_W'(cfg.idle_interval_ms)) begin
                            st_nxt.idle_flashing = 1'b1;
                            st_nxt.elapsed_ms    = '0;
                        end
                    end else begin
                        run = 1'b1;
                    end
                end
                MODE_SENDING: run = 1'b1;
                default: ;
            endcase

            // shared flash unit: off phase then lit phase, each longer than dur
            if (run && (e_inc > ELAPSED_W'(dur))) begin
                st_nxt.elapsed_ms = '0;
                if (!st_cur.flash_lit_phase) begin
                    st_nxt.led_lit         = 1'b1;
                    st_nxt.flash_lit_phase = 1'b1;
                end else begin
                    st_nxt.led_lit         = 1'b0;
                    st_nxt.flash_lit_phase = 1'b0;
                    st_nxt.flash_count     = cnt_inc;
                    if (cnt_inc == target) begin
                        st_nxt.flash_count = '0;
                        done               = 1'b1;
                    end
                end
            end

            if (done) begin
                if (st_cur.mode == MODE_IDLE) begin
                    st_nxt.idle_flashing = 1'b0;
                end else begin
                    st_nxt.mode    = MODE_IDLE;
                    st_nxt.led_lit = 1'b0;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/status_led_pattern_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// status_led_pattern_sequencer
// Status LED driver: idle blink, sending flashes, steady modes.
// ----------------------------------------------------------------------------
// Each input transaction is a 1 ms tick (tuser 0) or a mode change (tuser 1,
// mode in tdata). The block takes one transaction per clock while s_tready is
// high; its result (LED level and current mode) appears on the master side
// in the cycle after acceptance, from a single output register. s_tready
// drops only while that register holds a result the downstream has not taken.
// Configuration writes should be issued while no result is pending.
// ----------------------------------------------------------------------------
module status_led_pattern_sequencer (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire  [7:0] s_tdata,   // [2:0] new_mode
    input  wire        s_tuser,   // [0] cmd
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata,   // [0] led_on, [3:1] mode_now
    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire  [slps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire  [slps_pkg::CFG_DAT_W-1:0] cfg_data
);
    import slps_pkg::*;

    slps_state_t st_reg;
    slps_state_t st_next;
    slps_cfg_t   cfg_reg;
    logic        m_valid_reg;
    logic [7:0]  m_data_reg;
    logic        s_xfer;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign s_xfer    = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    slps_step u_step (
        .st_cur   (st_reg),
        .cfg      (cfg_reg),
        .cmd      (s_tuser),
        .new_mode (s_tdata[2:0]),
        .st_nxt   (st_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.idle_interval_ms <= IDLE_INTERVAL_RST;
            cfg_reg.blink_ms         <= BLINK_MS_RST;
            cfg_reg.flash_ms         <= FLASH_MS_RST;
            cfg_reg.send_flashes     <= SEND_FLASHES_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_IDLE_INTERVAL: cfg_reg.idle_interval_ms <= cfg_data;
                REG_BLINK_MS:      cfg_reg.blink_ms         <= cfg_data[DUR_W-1:0];
                REG_FLASH_MS:      cfg_reg.flash_ms         <= cfg_data[DUR_W-1:0];
                REG_SEND_FLASHES:  cfg_reg.send_flashes     <= cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_xfer) begin
                st_reg      <= st_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            m_data_reg <= {4'b0000, st_next.mode, st_next.led_lit};
        end
    end

    // ---------------------------------------------------------------- checks
    a_mode_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.mode <= MODE_SLEEPING)
        else $error("mode register out of range");

    a_set_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && (s_tuser == CMD_SET_MODE) && (s_tdata[2:0] <= MODE_SLEEPING)
        |=> st_reg.mode == $past(s_tdata[2:0]))
        else $error("mode change not applied");

    a_result_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> m_tvalid && (m_tdata[0] == st_reg.led_lit)
                   && (m_tdata[3:1] == st_reg.mode))
        else $error("result does not reflect state");

    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result stalled");

endmodule
`default_nettype wire
